// ===== design/sibd_pkg.sv =====
// Shared types and constants for the signed integer to base digits converter.
package sibd_pkg;

	localparam int DEF_MAX_RADIX  = 16;
	localparam int DEF_VALUE_BITS = 32;

	localparam int RADIX_W        = 5;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 64;
	localparam int SYM_W          = 8;
	localparam int SYMS_PER_WORD  = CFG_DATA_W / SYM_W;

	localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
	localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIX      = 2'd0,
		REG_ALPHA_LOW  = 2'd1,
		REG_ALPHA_HIGH = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic done;
		logic quo_zero;
	} div_sts_t;

endpackage

// ===== design/sibd_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, narrow remainder.
module sibd_divider import sibd_pkg::*; #(
	parameter int VALUE_BITS = DEF_VALUE_BITS,
	parameter int REM_W      = $clog2(DEF_MAX_RADIX)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  div_ctl_t              ctl,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [REM_W:0]        divisor,
	output div_sts_t              sts,
	output logic [REM_W-1:0]      remainder
);

	localparam int CNT_W = $clog2(VALUE_BITS);

	logic [VALUE_BITS-1:0] quo_q;
	logic [REM_W-1:0]      rem_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [REM_W:0]        trial;
	logic [REM_W:0]        diff;
	logic                  ge;
	logic [REM_W-1:0]      rem_nxt;

	always_comb begin
		trial   = {rem_q, quo_q[VALUE_BITS-1]};
		ge      = (trial >= divisor);
		diff    = trial - divisor;
		rem_nxt = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			quo_q <= dividend;
		end else if (busy_q) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], ge};
			rem_q <= rem_nxt;
			cnt_q <= cnt_q - 1'b1;
		end
		if (ctl.start) begin
			rem_q <= '0;
			cnt_q <= CNT_W'(VALUE_BITS - 1);
		end
	end

	assign sts.done     = done_q;
	assign sts.quo_zero = (quo_q == '0);
	assign remainder    = rem_q;

endmodule

// ===== design/signed_integer_to_base_digits.sv =====
// Top level of the signed integer to base digits converter.
// Converts one signed VALUE_BITS-bit value into ASCII characters in the
// configured radix, most significant digit first, with a leading '-' for a
// negative value (the most negative value included) and final_res set on the
// last character. A value produces nothing when radix is below 2 or above
// MAX_RADIX, or when the first radix alphabet symbols repeat or contain '+'
// or '-'. Per value: the value is taken in, then the alphabet is checked one
// symbol per cycle against the later symbols in use, then each digit comes
// from the bit-serial divider, then the characters go out, the sign first,
// as the sink takes them. A new value is taken once the last character sits
// in the output register, so the sink may stall on it while the next
// conversion starts. Configuration writes land at once; write them only
// when idle.
module signed_integer_to_base_digits import sibd_pkg::*; #(
	parameter int MAX_RADIX  = DEF_MAX_RADIX,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	// input channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [VALUE_BITS-1:0] value,
	// output channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [SYM_W-1:0]             character,
	output logic                         final_res
);

	localparam int REM_W  = $clog2(MAX_RADIX);   // digit index width
	localparam int DCNT_W = $clog2(VALUE_BITS + 1);

	// config registers
	logic [RADIX_W-1:0]    radix_q;
	logic [CFG_DATA_W-1:0] alpha_low_q;
	logic [CFG_DATA_W-1:0] alpha_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q      <= '0;
			alpha_low_q  <= '0;
			alpha_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_RADIX:      radix_q      <= cfg_data[RADIX_W-1:0];
				REG_ALPHA_LOW:  alpha_low_q  <= cfg_data;
				REG_ALPHA_HIGH: alpha_high_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	// symbol table view of the alphabet registers
	logic [SYM_W-1:0] sym [MAX_RADIX];

	always_comb begin
		for (int k = 0; k < MAX_RADIX; k++) begin
			if (k < SYMS_PER_WORD)
				sym[k] = alpha_low_q[SYM_W*k +: SYM_W];
			else
				sym[k] = alpha_high_q[SYM_W*(k-SYMS_PER_WORD) +: SYM_W];
		end
	end

	// control state
	state_t           state_q, state_d;
	logic [REM_W-1:0] chk_idx_q;
	logic             neg_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [REM_W-1:0] stack_q [VALUE_BITS];   // digit LIFO, top at entry 0

	logic             out_valid_q;
	logic [SYM_W-1:0] char_q;
	logic             final_q;

	// divider
	div_ctl_t              div_ctl;
	div_sts_t              div_sts;
	logic [VALUE_BITS-1:0] magnitude;
	logic [REM_W-1:0]      div_rem;

	assign magnitude = value[VALUE_BITS-1] ? (VALUE_BITS'(0) - $unsigned(value))
	                                       : $unsigned(value);

	sibd_divider #(
		.VALUE_BITS (VALUE_BITS),
		.REM_W      (REM_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (div_ctl),
		.dividend  (magnitude),
		.divisor   (radix_q[REM_W:0]),
		.sts       (div_sts),
		.remainder (div_rem)
	);

	// alphabet check, one symbol per cycle
	logic bad_radix;
	logic bad_sym;
	logic chk_last;

	always_comb begin
		bad_radix = (radix_q < RADIX_W'(2)) || (radix_q > RADIX_W'(MAX_RADIX));
		bad_sym   = (sym[chk_idx_q] == SYM_MINUS) || (sym[chk_idx_q] == SYM_PLUS);
		for (int j = 0; j < MAX_RADIX; j++) begin
			if (RADIX_W'(j) > RADIX_W'(chk_idx_q) && RADIX_W'(j) < radix_q &&
			    sym[j] == sym[chk_idx_q])
				bad_sym = 1'b1;
		end
		chk_last = (RADIX_W'(chk_idx_q) + RADIX_W'(1) == radix_q);
	end

	// output slot free for a new character
	logic slot_free;
	assign slot_free = !out_valid_q || out_ready;

	logic push, pop, load_sign, load_digit;

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		div_ctl.load  = 1'b0;
		div_ctl.start = 1'b0;
		push          = 1'b0;
		pop           = 1'b0;
		load_sign     = 1'b0;
		load_digit    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready     = 1'b1;
				div_ctl.load = in_valid;
				if (in_valid)
					state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (bad_radix || bad_sym) begin
					state_d = ST_IDLE;          // unusable radix or alphabet: drop value
				end else if (chk_last) begin
					div_ctl.start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_sts.done) begin
					push = 1'b1;
					if (div_sts.quo_zero)
						state_d = neg_q ? ST_SIGN : ST_EMIT;
					else
						div_ctl.start = 1'b1;
				end
			end
			ST_SIGN: begin
				if (slot_free) begin
					load_sign = 1'b1;
					state_d   = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					load_digit = 1'b1;
					pop        = 1'b1;
					if (dcnt_q == DCNT_W'(1))
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chk_idx_q   <= '0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE)
				chk_idx_q <= '0;
			else if (state_q == ST_CHECK)
				chk_idx_q <= chk_idx_q + 1'b1;
			if (push)
				dcnt_q <= dcnt_q + 1'b1;
			else if (pop)
				dcnt_q <= dcnt_q - 1'b1;
			if (load_sign || load_digit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (div_ctl.load)
			neg_q <= value[VALUE_BITS-1];
		if (push) begin
			stack_q[0] <= div_rem;
			for (int k = 1; k < VALUE_BITS; k++)
				stack_q[k] <= stack_q[k-1];
		end else if (pop) begin
			for (int k = 0; k < VALUE_BITS - 1; k++)
				stack_q[k] <= stack_q[k+1];
		end
		if (load_sign) begin
			char_q  <= SYM_MINUS;
			final_q <= 1'b0;
		end else if (load_digit) begin
			char_q  <= sym[stack_q[0]];
			final_q <= (dcnt_q == DCNT_W'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign final_res = final_q;

endmodule

// ===== verif/signed_integer_to_base_digits_test.sv =====
// Self-checking testbench for the signed integer to base digits converter.
module signed_integer_to_base_digits_test;
	import sibd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_RADIX     = DEF_MAX_RADIX;
	localparam int VALUE_BITS    = DEF_VALUE_BITS;
	// quiet cycles after the last character before touching the registers;
	// a value that yields nothing is gone well within this
	localparam int SETTLE_CYCLES = 150;
	// index 3 maps to no register; a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

	// decimal/upper-case hex alphabet, digit 0 in the lowest byte
	localparam logic [CFG_DATA_W-1:0] DEC_LO = "76543210";
	localparam logic [CFG_DATA_W-1:0] DEC_HI = "FEDCBA98";

	typedef struct packed {
		logic [SYM_W-1:0] ch;
		logic             last;
	} char_rec_t;

	typedef enum int {
		SET_CLEAN,
		SET_REPEAT,
		SET_SIGN,
		SET_BAD_RADIX
	} setting_kind_t;

	// Tracks the characters each accepted value must turn into, using its
	// own copy of the three registers.
	class digit_tracker;
		logic [RADIX_W-1:0]    radix;
		logic [CFG_DATA_W-1:0] alpha_lo;
		logic [CFG_DATA_W-1:0] alpha_hi;
		char_rec_t             pending_chars[$];
		int                    values_taken;
		int                    values_silent;
		int                    chars_seen;
		int                    errors;

		function new();
			radix    = '0;
			alpha_lo = '0;
			alpha_hi = '0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_RADIX:      radix    = data[RADIX_W-1:0];
				REG_ALPHA_LOW:  alpha_lo = data;
				REG_ALPHA_HIGH: alpha_hi = data;
				default: ;
			endcase
		endfunction

		function logic [SYM_W-1:0] symbol_of(int k);
			if (k < SYMS_PER_WORD)
				return alpha_lo[SYM_W*k +: SYM_W];
			return alpha_hi[SYM_W*(k-SYMS_PER_WORD) +: SYM_W];
		endfunction

		// radix in range, no sign symbol and no repeat among the digits in use
		function bit alphabet_ok();
			logic [SYM_W-1:0] s;
			if (radix < 2 || radix > MAX_RADIX)
				return 1'b0;
			for (int i = 0; i < radix; i++) begin
				s = symbol_of(i);
				if (s == SYM_MINUS || s == SYM_PLUS)
					return 1'b0;
				for (int j = i + 1; j < radix; j++)
					if (s == symbol_of(j))
						return 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_value(logic signed [VALUE_BITS-1:0] v);
			logic [VALUE_BITS-1:0] mag;
			logic [VALUE_BITS-1:0] base;
			logic [SYM_W-1:0]      digits[$];
			bit                    negative;
			values_taken++;
			if (!alphabet_ok()) begin
				values_silent++;
				return;
			end
			negative = v[VALUE_BITS-1];
			mag      = negative ? (0 - $unsigned(v)) : $unsigned(v);
			base     = VALUE_BITS'(radix);
			do begin
				digits.push_front(symbol_of(int'(mag % base)));
				mag = mag / base;
			end while (mag != 0);
			if (negative)
				pending_chars.push_back('{ch: SYM_MINUS, last: 1'b0});
			for (int k = 0; k < digits.size(); k++)
				pending_chars.push_back('{ch: digits[k], last: (k == digits.size() - 1)});
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t ns: %s", $time, msg);
			errors++;
		endtask

		task check_char(logic [SYM_W-1:0] ch, logic last);
			char_rec_t want;
			chars_seen++;
			if (pending_chars.size() == 0) begin
				report($sformatf("unexpected character 8'h%02h final_res %0b", ch, last));
				return;
			end
			want = pending_chars.pop_front();
			if (ch !== want.ch)
				report($sformatf("character 8'h%02h, expected 8'h%02h", ch, want.ch));
			if (last !== want.last)
				report($sformatf("final_res %0b on 8'h%02h, expected %0b", last, ch, want.last));
		endtask
	endclass

	// block ports; every input starts at a known value
	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]         cfg_index = '0;
	logic [CFG_DATA_W-1:0]        cfg_data  = '0;
	logic                         in_valid  = 1'b0;
	logic                         in_ready;
	logic signed [VALUE_BITS-1:0] value     = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [SYM_W-1:0]             character;
	logic                         final_res;

	digit_tracker tracker;
	int send_idle_pct = 38;
	int recv_idle_pct = 72;
	int hold_req      = 0;   // posted at a falling edge, picked up by the sink
	int hold_left     = 0;
	int settings      = 0;

	signed_integer_to_base_digits i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.character (character),
		.final_res (final_res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Sink: random back-pressure, or a long hold-off when one is requested.
	// The count lives here so the sender keeps offering values meanwhile.
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Output monitor: handshake signals read at the edge, before any update.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_char(character, final_res);
	end

	// One value transfer. Valid stays high from one transfer straight into
	// the next unless the random gap drops it first.
	task automatic send_value(input logic signed [VALUE_BITS-1:0] v);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		tracker.note_value(v);
	endtask

	// Stop sending and wait until every expected character is out, then let
	// the block finish any value that yields nothing.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Writes all three registers back to back; upper radix bits are junk and
	// must be dropped. Optionally finishes with a write to the unused index.
	task automatic configure(input logic [RADIX_W-1:0] r, input logic [CFG_DATA_W-1:0] lo,
			input logic [CFG_DATA_W-1:0] hi, input bit spare = 1'b0);
		logic [CFG_DATA_W-1:0] rword;
		rword              = {$urandom, $urandom};
		rword[RADIX_W-1:0] = r;
		cfg_we    <= 1'b1;
		cfg_index <= REG_RADIX;
		cfg_data  <= rword;
		tracker.set_reg(REG_RADIX, rword);
		@(posedge clk);
		cfg_index <= REG_ALPHA_LOW;
		cfg_data  <= lo;
		tracker.set_reg(REG_ALPHA_LOW, lo);
		@(posedge clk);
		cfg_index <= REG_ALPHA_HIGH;
		cfg_data  <= hi;
		tracker.set_reg(REG_ALPHA_HIGH, hi);
		@(posedge clk);
		if (spare) begin
			cfg_index <= REG_UNMAPPED;
			cfg_data  <= {$urandom, $urandom};
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings++;
	endtask

	// Long sink hold-off; valid drops for one cycle so no transfer repeats.
	task automatic hold_receiver(input int cycles);
		in_valid <= 1'b0;
		@(negedge clk);
		hold_req = cycles;
		@(posedge clk);
	endtask

	// Random setting: mostly a clean alphabet, sometimes a repeat, a sign
	// symbol (often in the last slot in use) or a radix outside 2..16.
	function automatic void pick_setting(output logic [RADIX_W-1:0] r,
			output logic [CFG_DATA_W-1:0] lo, output logic [CFG_DATA_W-1:0] hi);
		logic [SYM_W-1:0] sym[16];
		bit               used[256];
		logic [SYM_W-1:0] s;
		setting_kind_t    kind;
		int               i;
		int               j;
		int               roll;
		for (int k = 0; k < 16; k++) begin
			do
				s = SYM_W'($urandom_range(0, 255));
			while (used[s] || s == SYM_MINUS || s == SYM_PLUS);
			used[s] = 1'b1;
			sym[k]  = s;
		end
		roll = $urandom_range(0, 9);
		kind = (roll < 7) ? SET_CLEAN : (roll == 7) ? SET_REPEAT :
			(roll == 8) ? SET_SIGN : SET_BAD_RADIX;
		// radix 2..4 converts slowly, so it gets the smaller share
		r = ($urandom_range(0, 3) == 0) ? RADIX_W'($urandom_range(2, 4))
			: RADIX_W'($urandom_range(5, 16));
		case (kind)
			SET_REPEAT: begin
				j      = $urandom_range(1, r - 1);
				i      = $urandom_range(0, j - 1);
				sym[j] = sym[i];
			end
			SET_SIGN: begin
				j      = ($urandom_range(0, 1) == 1) ? r - 1 : $urandom_range(0, r - 1);
				sym[j] = ($urandom_range(0, 1) == 1) ? SYM_PLUS : SYM_MINUS;
			end
			SET_BAD_RADIX: begin
				r = ($urandom_range(0, 2) == 0) ? RADIX_W'($urandom_range(0, 1))
					: RADIX_W'($urandom_range(17, 31));
			end
			default: ;
		endcase
		lo = '0;
		hi = '0;
		for (int k = 0; k < SYMS_PER_WORD; k++) begin
			lo[SYM_W*k +: SYM_W] = sym[k];
			hi[SYM_W*k +: SYM_W] = sym[k + SYMS_PER_WORD];
		end
	endfunction

	// full-range words, short numbers of either sign, powers of two and their
	// neighbours, and the extremes
	function automatic logic signed [VALUE_BITS-1:0] random_value();
		logic [VALUE_BITS-1:0] v;
		int                    pick;
		pick = $urandom_range(0, 19);
		if (pick < 9) begin
			v = $urandom;
		end else if (pick < 15) begin
			v = $urandom_range(0, 300);
			if ($urandom_range(0, 1) == 1)
				v = 0 - v;
		end else if (pick < 17) begin
			v = (VALUE_BITS'(1) << $urandom_range(0, VALUE_BITS - 1))
				+ VALUE_BITS'($urandom_range(0, 2)) - VALUE_BITS'(1);
		end else begin
			case ($urandom_range(0, 4))
				0:       v = {1'b1, {(VALUE_BITS-1){1'b0}}};
				1:       v = {1'b0, {(VALUE_BITS-1){1'b1}}};
				2:       v = '0;
				3:       v = '1;
				default: v = {1'b1, {(VALUE_BITS-2){1'b0}}, 1'b1};
			endcase
		end
		return $signed(v);
	endfunction

	// Random settings until enough values have gone through a usable one;
	// values sent into an unusable setting are few and do not count.
	task automatic random_regime(input int target);
		logic [RADIX_W-1:0]    r;
		logic [CFG_DATA_W-1:0] lo;
		logic [CFG_DATA_W-1:0] hi;
		int                    useful;
		int                    burst;
		bit                    ok;
		useful = 0;
		while (useful < target) begin
			pick_setting(r, lo, hi);
			drain();
			configure(r, lo, hi);
			ok    = tracker.alphabet_ok();
			burst = ok ? $urandom_range(4, 10) : 2;
			repeat (burst)
				send_value(random_value());
			if (ok)
				useful += burst;
		end
	endtask

	initial begin
		tracker = new();
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part, sender 38% idle, sink 72% idle ---
		// radix still zero out of reset: nothing comes out
		send_value(12345);
		drain();
		configure(10, DEC_LO, DEC_HI, 1'b1);
		send_value(0);
		send_value(-1);
		send_value(32'sh7FFF_FFFF);
		send_value(32'sh8000_0000);   // most negative: sign plus exact magnitude
		send_value(1000000000);
		send_value(-987654321);
		drain();
		// radix 2: longest strings, 32 digits plus sign
		configure(2, DEC_LO, DEC_HI);
		send_value(32'sh8000_0000);
		send_value(32'sh7FFF_FFFF);
		drain();
		configure(16, DEC_LO, "fedcba98");
		send_value(32'shDEAD_BEEF);
		// sink holds off while the sender keeps offering, so the block fills
		// and holds in_ready low
		send_idle_pct = 0;
		hold_receiver(2000);
		send_value(1);
		send_value(-15);
		send_value(16);
		send_value(4095);
		send_value(-256);
		send_value(32'sh0001_0000);
		send_idle_pct = 38;
		// sender pauses here until every character has come
		drain();
		// zero byte as digit 0; duplicate zero bytes beyond the radix are fine
		configure(3, {40'd0, "zU", 8'h00}, '0);
		send_value(0);
		send_value(-8);
		drain();
		// repeated symbol between the two words
		configure(16, DEC_LO, {"0", "EDCBA98"});
		send_value(42);
		drain();
		// '+' in the last slot in use
		configure(16, DEC_LO, {"+", "EDCBA98"});
		send_value(42);
		drain();
		// sign symbols and repeats only past the radix: still usable
		configure(8, DEC_LO, "--------");
		send_value(-100);
		drain();
		// same alphabet, radix 9 pulls a '-' in as the last digit
		configure(9, DEC_LO, "--------");
		send_value(100);
		drain();
		configure(1, DEC_LO, DEC_HI);
		send_value(5);
		drain();
		configure(17, DEC_LO, DEC_HI);
		send_value(5);
		drain();
		configure(31, DEC_LO, DEC_HI);
		send_value(5);

		// --- random part in three pacing regimes ---
		random_regime(25);
		drain();
		send_idle_pct = 72;
		recv_idle_pct = 38;
		random_regime(25);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_regime(25);
		drain();

		if (tracker.pending_chars.size() != 0)
			tracker.report($sformatf("%0d characters never arrived",
				tracker.pending_chars.size()));
		$display("run: %0d values over %0d register settings, %0d of them silent",
			tracker.values_taken, settings, tracker.values_silent);
		$display("run: %0d characters checked, %0d mismatches",
			tracker.chars_seen, tracker.errors);
		if (tracker.errors == 0)
			$display("signed_integer_to_base_digits_test passed");
		else
			$display("signed_integer_to_base_digits_test failed");
		$finish;
	end

	// hang guard, several times the slowest legal run
	initial begin
		#12ms;
		$display("TIMEOUT at %0t ns", $time);
		$display("signed_integer_to_base_digits_test failed");
		$finish;
	end

endmodule
